FILE: hdl/fbrf_pkg.sv
// Shared types, constants and helpers of the frame buffer rectangle fill engine.
package fbrf_pkg;

  localparam int BYTE_W     = 8;
  localparam int RES_W      = 11;  // resolution registers
  localparam int PB_W       = 3;   // bytes per pixel register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int HV_W       = 2 * RES_W;       // pixels in the active area
  localparam int MUL_AW     = HV_W;            // shared multiplier, operand a
  localparam int MUL_BW     = RES_W;           // shared multiplier, operand b
  localparam int BOFF_W     = RES_W + PB_W;    // byte offset within one line
  localparam int CHK_AW     = 23;              // widest check byte address + 1

  localparam int DEF_MAX_H_RES = 1024;
  localparam int DEF_MAX_V_RES = 1024;
  localparam int DEF_FB_BYTES  = 4194304;

  localparam logic [RES_W-1:0] H_RES_RST = 11'd1024;
  localparam logic [RES_W-1:0] V_RES_RST = 11'd768;
  localparam logic [PB_W-1:0]  PB_RST    = 3'd4;

  localparam logic [1:0] ACT_FILL  = 2'd0;
  localparam logic [1:0] ACT_CHECK = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_H_RES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_V_RES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIX_BYTES = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [31:0] pixel_color;
    logic [19:0] pixel_index;
  } fbrf_in_t;

  typedef struct packed {
    logic [1:0] done_action;
    logic       pixel_match;
  } fbrf_out_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] wr_data;
  } fbrf_mreq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fbrf_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_SETUP,
    ST_MUL_ALO,
    ST_MUL_AHI,
    ST_MUL_BHI,
    ST_MUL_STEP,
    ST_ROW,
    ST_SPAN_A,
    ST_SPAN_B,
    ST_MUL_HV,
    ST_MUL_TOT,
    ST_CLEAR,
    ST_MUL_POS,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_DONE
  } state_t;

  // byte k of a stored pixel; bytes above the colour word are zero
  function automatic logic [BYTE_W-1:0] pixel_byte(input logic [31:0] color,
                                                   input logic [PB_W-1:0] k);
    logic [BYTE_W-1:0] b;
    case (k)
      3'd0:    b = color[7:0];
      3'd1:    b = color[15:8];
      3'd2:    b = color[23:16];
      3'd3:    b = color[31:24];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/fbrf_seq.sv
// Command sequencer: address generation, shared multiplier and pixel compare.
module fbrf_seq #(
  parameter int MAX_H_RES = fbrf_pkg::DEF_MAX_H_RES,
  parameter int MAX_V_RES = fbrf_pkg::DEF_MAX_V_RES,
  parameter int FB_BYTES  = fbrf_pkg::DEF_FB_BYTES,
  localparam int MEM_AW   = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  fbrf_pkg::fbrf_in_t           in_data,
  input  logic [fbrf_pkg::RES_W-1:0]   h_res,
  input  logic [fbrf_pkg::RES_W-1:0]   v_res,
  input  logic [fbrf_pkg::PB_W-1:0]    pix_bytes,
  input  logic                         out_free,
  input  logic [fbrf_pkg::BYTE_W-1:0]  rd_data,
  output fbrf_pkg::fbrf_mreq_t         mem_req,
  output logic [MEM_AW-1:0]            mem_idx,
  output fbrf_pkg::fbrf_stat_t         stat,
  output fbrf_pkg::fbrf_out_t          result
);
  import fbrf_pkg::*;

  localparam int RES_MAX = (1 << RES_W) - 1;
  localparam int PB_MAX  = (1 << PB_W) - 1;
  localparam int LIM_H   = (MAX_H_RES < RES_MAX) ? MAX_H_RES : RES_MAX;
  localparam int LIM_V   = (MAX_V_RES < RES_MAX) ? MAX_V_RES : RES_MAX;
  localparam int FILL_AW = $clog2(LIM_H * LIM_V * PB_MAX + 1);
  localparam int ADDR_W  = (FILL_AW > CHK_AW) ? FILL_AW : CHK_AW;

  state_t              state_r, state_nxt;
  fbrf_in_t            item_r, item_nxt;
  logic [RES_W-1:0]    a_lo_r, a_lo_nxt, a_hi_r, a_hi_nxt, b_hi_r, b_hi_nxt;
  logic [BOFF_W-1:0]   a_lo_b_r, a_lo_b_nxt, a_hi_b_r, a_hi_b_nxt, b_hi_b_r, b_hi_b_nxt;
  logic [BOFF_W-1:0]   step_r, step_nxt;
  logic [HV_W-1:0]     hv_r, hv_nxt;
  logic [RES_W-1:0]    y_r, y_nxt;
  logic [ADDR_W-1:0]   line_r, line_nxt, cur_r, cur_nxt, end_r, end_nxt;
  logic [PB_W-1:0]     k_r, k_nxt;
  logic                match_r, match_nxt;
  logic                rd_ok_r, rd_ok_nxt;

  logic [RES_W-1:0]         h_eff, v_eff;
  logic [MUL_AW-1:0]        mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic [MUL_AW+MUL_BW-1:0] mul_p;
  logic [16:0]              x_end;
  logic [15:0]              row_off;
  logic                     row_hit, last_row, in_range, span_go, chk_last;
  logic [31:0]              cur_ext;
  logic [PB_W-1:0]          k_step;
  logic [BYTE_W-1:0]        rd_byte;

  assign h_eff = (32'(h_res) < MAX_H_RES) ? h_res : RES_W'(MAX_H_RES);
  assign v_eff = (32'(v_res) < MAX_V_RES) ? v_res : RES_W'(MAX_V_RES);

  assign mul_p    = mul_a * mul_b;
  assign x_end    = {1'b0, item_r.left} + {1'b0, item_r.rect_width};
  assign row_off  = 16'(y_r) - item_r.top;
  assign row_hit  = row_off < item_r.rect_height;
  assign last_row = (y_r == v_eff - RES_W'(1));
  assign cur_ext  = 32'(cur_r);
  assign in_range = cur_ext < FB_BYTES;
  assign span_go  = (cur_r < end_r) && in_range;
  assign mem_idx  = cur_ext[MEM_AW-1:0];
  assign k_step   = (k_r == pix_bytes - PB_W'(1)) ? '0 : k_r + PB_W'(1);
  assign rd_byte  = rd_ok_r ? rd_data : '0;
  // a check covers at least the four colour bytes and at least the stored pixel
  assign chk_last = (k_r >= PB_W'(3)) && ({1'b0, k_r} + 4'd1 >= {1'b0, pix_bytes});

  assign result.done_action = item_r.action;
  assign result.pixel_match = match_r;

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    a_lo_nxt   = a_lo_r;
    a_hi_nxt   = a_hi_r;
    b_hi_nxt   = b_hi_r;
    a_lo_b_nxt = a_lo_b_r;
    a_hi_b_nxt = a_hi_b_r;
    b_hi_b_nxt = b_hi_b_r;
    step_nxt   = step_r;
    hv_nxt     = hv_r;
    y_nxt      = y_r;
    line_nxt   = line_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    k_nxt      = k_r;
    match_nxt  = match_r;
    rd_ok_nxt  = rd_ok_r;
    mul_a      = '0;
    mul_b      = '0;
    mem_req    = '0;
    stat.busy  = (state_r != ST_IDLE);
    stat.done  = 1'b0;
    mem_req.wr_data = (state_r == ST_CLEAR) ? '0 : pixel_byte(item_r.pixel_color, k_r);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          match_nxt = (in_data.action == ACT_CHECK);
          case (in_data.action)
            ACT_FILL:  state_nxt = ST_FILL_SETUP;
            ACT_CHECK: state_nxt = ST_MUL_POS;
            ACT_CLEAR: state_nxt = ST_MUL_HV;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FILL_SETUP: begin
        // covered columns: the direct span and the part that wraps past 65535
        a_lo_nxt = '0;
        a_hi_nxt = '0;
        b_hi_nxt = '0;
        if ({1'b0, item_r.left} < {1'b0, 5'd0, h_eff}) begin
          a_lo_nxt = item_r.left[RES_W-1:0];
          a_hi_nxt = (x_end < {6'd0, h_eff}) ? x_end[RES_W-1:0] : h_eff;
        end
        if (x_end[16] && (x_end[15:0] != 16'd0)) begin
          b_hi_nxt = (x_end[15:0] < {5'd0, h_eff}) ? x_end[RES_W-1:0] : h_eff;
        end
        if ((item_r.rect_width == 16'd0) || (item_r.rect_height == 16'd0) ||
            (v_eff == '0)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL_ALO;
        end
      end
      ST_MUL_ALO: begin
        mul_a      = MUL_AW'(a_lo_r);
        mul_b      = MUL_BW'(pix_bytes);
        a_lo_b_nxt = mul_p[BOFF_W-1:0];
        state_nxt  = ST_MUL_AHI;
      end
      ST_MUL_AHI: begin
        mul_a      = MUL_AW'(a_hi_r);
        mul_b      = MUL_BW'(pix_bytes);
        a_hi_b_nxt = mul_p[BOFF_W-1:0];
        state_nxt  = ST_MUL_BHI;
      end
      ST_MUL_BHI: begin
        mul_a      = MUL_AW'(b_hi_r);
        mul_b      = MUL_BW'(pix_bytes);
        b_hi_b_nxt = mul_p[BOFF_W-1:0];
        state_nxt  = ST_MUL_STEP;
      end
      ST_MUL_STEP: begin
        mul_a     = MUL_AW'(h_eff);
        mul_b     = MUL_BW'(pix_bytes);
        step_nxt  = mul_p[BOFF_W-1:0];
        y_nxt     = '0;
        line_nxt  = '0;
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        if (row_hit) begin
          cur_nxt   = line_r + ADDR_W'(a_lo_b_r);
          end_nxt   = line_r + ADDR_W'(a_hi_b_r);
          k_nxt     = '0;
          state_nxt = ST_SPAN_A;
        end else if (last_row) begin
          state_nxt = ST_DONE;
        end else begin
          y_nxt    = y_r + RES_W'(1);
          line_nxt = line_r + ADDR_W'(step_r);
        end
      end
      ST_SPAN_A: begin
        if (span_go) begin
          mem_req.wr_en = 1'b1;
          cur_nxt       = cur_r + ADDR_W'(1);
          k_nxt         = k_step;
        end else begin
          cur_nxt   = line_r;
          end_nxt   = line_r + ADDR_W'(b_hi_b_r);
          k_nxt     = '0;
          state_nxt = ST_SPAN_B;
        end
      end
      ST_SPAN_B: begin
        if (span_go) begin
          mem_req.wr_en = 1'b1;
          cur_nxt       = cur_r + ADDR_W'(1);
          k_nxt         = k_step;
        end else if (last_row) begin
          state_nxt = ST_DONE;
        end else begin
          y_nxt     = y_r + RES_W'(1);
          line_nxt  = line_r + ADDR_W'(step_r);
          state_nxt = ST_ROW;
        end
      end
      ST_MUL_HV: begin
        mul_a     = MUL_AW'(h_eff);
        mul_b     = MUL_BW'(v_eff);
        hv_nxt    = mul_p[HV_W-1:0];
        state_nxt = ST_MUL_TOT;
      end
      ST_MUL_TOT: begin
        mul_a     = MUL_AW'(hv_r);
        mul_b     = MUL_BW'(pix_bytes);
        end_nxt   = mul_p[ADDR_W-1:0];
        cur_nxt   = '0;
        k_nxt     = '0;
        state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (span_go) begin
          mem_req.wr_en = 1'b1;
          cur_nxt       = cur_r + ADDR_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL_POS: begin
        mul_a     = MUL_AW'(item_r.pixel_index);
        mul_b     = MUL_BW'(pix_bytes);
        cur_nxt   = mul_p[ADDR_W-1:0];
        k_nxt     = '0;
        state_nxt = ST_CHK_RD;
      end
      ST_CHK_RD: begin
        mem_req.rd_en = (k_r < pix_bytes) && in_range;
        rd_ok_nxt     = mem_req.rd_en;
        state_nxt     = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (rd_byte != pixel_byte(item_r.pixel_color, k_r)) begin
          match_nxt = 1'b0;
        end
        cur_nxt = cur_r + ADDR_W'(1);
        k_nxt   = k_r + PB_W'(1);
        state_nxt = chk_last ? ST_DONE : ST_CHK_RD;
      end
      ST_DONE: begin
        stat.done = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    a_lo_r   <= a_lo_nxt;
    a_hi_r   <= a_hi_nxt;
    b_hi_r   <= b_hi_nxt;
    a_lo_b_r <= a_lo_b_nxt;
    a_hi_b_r <= a_hi_b_nxt;
    b_hi_b_r <= b_hi_b_nxt;
    step_r   <= step_nxt;
    hv_r     <= hv_nxt;
    y_r      <= y_nxt;
    line_r   <= line_nxt;
    cur_r    <= cur_nxt;
    end_r    <= end_nxt;
    k_r      <= k_nxt;
    match_r  <= match_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

endmodule

FILE: hdl/framebuffer_rect_fill.sv
// Top level of the frame buffer rectangle fill engine: registers, byte store, result register.
// One command is worked at a time through a single byte-wide store port, so time follows the
// bytes touched. Fill: setup of the column bounds in bytes and the line step, then a visit of
// each active line, writing the covered bytes one at a time on each line that the rectangle
// covers, then the hand-over of the result. Clear: writes H*V*(bytes per pixel) bytes (capped
// at the store size). Check: compares max(bytes per pixel, 4) bytes, each read through the
// registered store read. The store has no reset: a pixel must be written or cleared before it
// is checked. in_stall is high from the accepted transfer until the result is loaded into the
// output register; the output register lets the next command in while a result still waits.
module framebuffer_rect_fill #(
  parameter int MAX_H_RES = fbrf_pkg::DEF_MAX_H_RES,
  parameter int MAX_V_RES = fbrf_pkg::DEF_MAX_V_RES,
  parameter int FB_BYTES  = fbrf_pkg::DEF_FB_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fbrf_pkg::fbrf_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fbrf_pkg::fbrf_out_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [fbrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbrf_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import fbrf_pkg::*;

  localparam int MEM_AW = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;

  logic [RES_W-1:0]  h_res_r, v_res_r;
  logic [PB_W-1:0]   pix_bytes_r;
  logic              out_valid_r;
  fbrf_out_t         out_data_r;
  logic              out_free;
  logic              out_load;

  fbrf_mreq_t        mem_req;
  logic [MEM_AW-1:0] mem_idx;
  fbrf_stat_t        stat;
  fbrf_out_t         result;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] mem [FB_BYTES];

  fbrf_seq #(
    .MAX_H_RES (MAX_H_RES),
    .MAX_V_RES (MAX_V_RES),
    .FB_BYTES  (FB_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .h_res     (h_res_r),
    .v_res     (v_res_r),
    .pix_bytes (pix_bytes_r),
    .out_free  (out_free),
    .rd_data   (rd_data_r),
    .mem_req   (mem_req),
    .mem_idx   (mem_idx),
    .stat      (stat),
    .result    (result)
  );

  assign in_stall  = stat.busy;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = stat.done && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_res_r     <= H_RES_RST;
      v_res_r     <= V_RES_RST;
      pix_bytes_r <= PB_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_H_RES:     h_res_r     <= cfg_wr_data[RES_W-1:0];
        CFG_V_RES:     v_res_r     <= cfg_wr_data[RES_W-1:0];
        CFG_PIX_BYTES: pix_bytes_r <= cfg_wr_data[PB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  // byte store, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_idx] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_idx];
    end
  end

  // an accepted command keeps the input side stalled until it completes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted transfer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.done))
    else $error("result presented without a finished command");

  a_one_store_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("store read and written in the same cycle");

endmodule

FILE: verif/fbrf_checker.sv
// Checker for the rectangle fill engine: mirrors the frame buffer, predicts each result, compares.
`timescale 1ns / 1ps
module fbrf_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  fbrf_pkg::fbrf_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  fbrf_pkg::fbrf_out_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [fbrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbrf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output int                              mismatches,
  output int                              pending
);
  import fbrf_pkg::*;

  // image of the byte store; zero where the block's contents are still undefined
  bit [7:0] fb_image [0:DEF_FB_BYTES-1];

  logic [RES_W-1:0] h_reg;
  logic [RES_W-1:0] v_reg;
  logic [PB_W-1:0]  pb_reg;

  fbrf_out_t expected_done [$];

  function automatic int unsigned line_pixels();
    return (h_reg > DEF_MAX_H_RES) ? DEF_MAX_H_RES : h_reg;
  endfunction

  function automatic int unsigned frame_lines();
    return (v_reg > DEF_MAX_V_RES) ? DEF_MAX_V_RES : v_reg;
  endfunction

  function automatic void paint_pixel(input int unsigned x, input int unsigned y,
                                      input logic [31:0] color);
    longint unsigned base;
    longint unsigned addr;
    base = (64'(y) * line_pixels() + x) * pb_reg;
    for (int k = 0; k < pb_reg; k++) begin
      addr = base + k;
      // bytes above the colour word of a wide pixel are stored as zero
      if (addr < DEF_FB_BYTES) fb_image[addr] = (k < 4) ? color[8*k +: 8] : 8'h00;
    end
  endfunction

  function automatic void paint_rect(input fbrf_in_t item);
    int unsigned hr;
    int unsigned vr;
    int unsigned end_x;
    int unsigned a_lo;
    int unsigned a_hi;
    int unsigned b_hi;
    hr = line_pixels();
    vr = frame_lines();
    a_lo = 0;
    a_hi = 0;
    b_hi = 0;
    if (item.rect_width == 0 || item.rect_height == 0) return;
    end_x = 32'(item.left) + 32'(item.rect_width);
    // covered columns: the run from left, plus the part that wraps past 65535
    if (item.left < hr) begin
      a_lo = item.left;
      a_hi = (end_x < hr) ? end_x : hr;
    end
    if (end_x > 65536) begin
      b_hi = end_x - 65536;
      if (b_hi > hr) b_hi = hr;
    end
    for (int unsigned y = 0; y < vr; y++) begin
      if (16'(y - item.top) < item.rect_height) begin
        for (int unsigned x = a_lo; x < a_hi; x++) paint_pixel(x, y, item.pixel_color);
        for (int unsigned x = 0; x < b_hi; x++) paint_pixel(x, y, item.pixel_color);
      end
    end
  endfunction

  function automatic bit probe_pixel(input logic [19:0] pos, input logic [31:0] color);
    longint unsigned base;
    longint unsigned addr;
    logic [63:0] val;
    base = 64'(pos) * pb_reg;
    val = '0;
    for (int k = 0; k < pb_reg; k++) begin
      addr = base + k;
      if (addr < DEF_FB_BYTES) val[8*k +: 8] = fb_image[addr];
    end
    return val == {32'h0, color};
  endfunction

  function automatic void wipe_frame();
    longint unsigned n;
    n = 64'(line_pixels()) * frame_lines() * pb_reg;
    if (n > DEF_FB_BYTES) n = DEF_FB_BYTES;
    for (longint unsigned i = 0; i < n; i++) fb_image[i] = 8'h00;
  endfunction

  function automatic fbrf_out_t run_command(input fbrf_in_t item);
    fbrf_out_t res;
    res.done_action = item.action;
    res.pixel_match = 1'b0;
    case (item.action)
      ACT_FILL:  paint_rect(item);
      ACT_CHECK: res.pixel_match = probe_pixel(item.pixel_index, item.pixel_color);
      ACT_CLEAR: wipe_frame();
      default:   ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns fbrf_checker: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    fbrf_out_t want;
    if (!rst_n) begin
      h_reg = H_RES_RST;
      v_reg = V_RES_RST;
      pb_reg = PB_RST;
      expected_done.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_H_RES:     h_reg = cfg_wr_data[RES_W-1:0];
          CFG_V_RES:     v_reg = cfg_wr_data[RES_W-1:0];
          CFG_PIX_BYTES: pb_reg = cfg_wr_data[PB_W-1:0];
          default:       ;
        endcase
      end
      // the result side goes first: a result is always older than a command taken now
      if (out_valid && !out_stall) begin
        if (expected_done.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: action %0d match %0d",
                                    out_data.done_action, out_data.pixel_match));
        end else begin
          want = expected_done.pop_front();
          if (out_data.done_action !== want.done_action)
            report_mismatch($sformatf("done_action %0d, expected %0d",
                                      out_data.done_action, want.done_action));
          if (out_data.pixel_match !== want.pixel_match)
            report_mismatch($sformatf("pixel_match %0d, expected %0d (action %0d)",
                                      out_data.pixel_match, want.pixel_match,
                                      want.done_action));
        end
      end
      if (in_valid && !in_stall) expected_done.push_back(run_command(in_data));
    end
    pending = expected_done.size();
  end

endmodule

FILE: verif/framebuffer_rect_fill_tb.sv
// Testbench top for the rectangle fill engine: command and register stimulus, and the verdict.
`timescale 1ns / 1ps
module framebuffer_rect_fill_tb;
  import fbrf_pkg::*;

  localparam logic [1:0] ACT_IDLE = 2'd3;  // no operation, echoed back
  localparam int PHASES = 15;

  // register settings per phase and the random commands sent under each
  int unsigned ph_h  [0:PHASES-1] = '{16, 1, 2047, 7, 13, 32, 0, 9, 20, 1024, 24, 10, 1, 40, 5};
  int unsigned ph_v  [0:PHASES-1] = '{8, 2047, 4, 5, 11, 16, 9, 0, 12, 1024, 24, 10, 1, 20, 3};
  int unsigned ph_pb [0:PHASES-1] = '{4, 1, 4, 7, 2, 3, 4, 1, 0, 5, 5, 6, 1, 1, 4};
  int unsigned ph_n  [0:PHASES-1] = '{80, 90, 40, 150, 150, 150, 60, 60, 100, 12, 150, 150, 80,
                                      150, 150};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  fbrf_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  fbrf_out_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  int                    mismatches;
  int                    pending;

  bit              quiet;          // no idling on either side
  int unsigned     sent;
  int unsigned     h_act;
  int unsigned     v_act;
  int unsigned     pb_cfg;
  longint unsigned known_len = 0;  // store bytes [0, known_len) have been cleared
  fbrf_in_t        last_fill = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  framebuffer_rect_fill dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  fbrf_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(0, 99) < 25);

  function automatic fbrf_in_t cmd(input logic [1:0] a, input logic [15:0] l, t, w, h,
                                   input logic [31:0] c, input logic [19:0] p);
    fbrf_in_t it;
    it.action = a;
    it.left = l;
    it.top = t;
    it.rect_width = w;
    it.rect_height = h;
    it.pixel_color = c;
    it.pixel_index = p;
    return it;
  endfunction

  // a check may only touch bytes that have been cleared, or lie past the store
  function automatic bit readable(input longint unsigned pos);
    longint unsigned lo;
    longint unsigned hi;
    lo = pos * pb_cfg;
    hi = lo + pb_cfg;
    if (hi > DEF_FB_BYTES) hi = DEF_FB_BYTES;
    return pb_cfg == 0 || lo >= DEF_FB_BYTES || hi <= known_len;
  endfunction

  function automatic logic [15:0] pick_coord(input int unsigned span);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, span + 2));
      6, 7:             return 16'hFFFF - 16'($urandom_range(0, 7));
      default:          return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_extent(input int unsigned span, input bit roomy);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (!roomy || r < 6) return 16'($urandom_range(1, 8));
    if (r < 8) return 16'($urandom_range(span, span + 3));
    if (r == 8) return 16'hFFFF - 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic fbrf_in_t random_item();
    fbrf_in_t it;
    int unsigned r;
    int unsigned x;
    int unsigned y;
    longint unsigned area_px;
    longint unsigned span;
    longint unsigned pos;
    bit hit;
    bit roomy;
    area_px = 64'(h_act) * v_act;
    span = (area_px + 3 > 20'hFFFFF) ? 20'hFFFFF : area_px + 3;
    roomy = area_px * pb_cfg <= 8192;
    it.left = 16'($urandom);
    it.top = 16'($urandom);
    it.rect_width = 16'($urandom);
    it.rect_height = 16'($urandom);
    it.pixel_color = $urandom;
    it.pixel_index = 20'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45) begin
      it.action = ACT_FILL;
      it.left = pick_coord(h_act);
      it.top = pick_coord(v_act);
      it.rect_width = pick_extent(h_act, roomy);
      it.rect_height = pick_extent(v_act, roomy);
    end else if (r < 88) begin
      it.action = ACT_CHECK;
      pos = 0;
      hit = 0;
      for (int t = 0; t < 4; t++) begin
        r = $urandom_range(0, 9);
        hit = 0;
        if (r < 5 && last_fill.rect_width != 0 && last_fill.rect_height != 0) begin
          // aim inside the latest rectangle so that matches are common
          x = (32'(last_fill.left) + $urandom_range(0, last_fill.rect_width - 1)) & 32'hFFFF;
          y = (32'(last_fill.top) + $urandom_range(0, last_fill.rect_height - 1)) & 32'hFFFF;
          if (x < h_act && y < v_act) begin
            pos = 64'(y) * h_act + x;
            hit = 1;
          end else begin
            pos = $urandom_range(0, span);
          end
        end else if (r < 8) begin
          pos = $urandom_range(0, span);
        end else begin
          pos = $urandom_range(0, 20'hFFFFF);
        end
        if (readable(pos)) break;
        pos = 0;
        hit = 0;
      end
      r = $urandom_range(0, 9);
      if (hit && r < 7)
        it.pixel_color = last_fill.pixel_color &
                         ((pb_cfg >= 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * pb_cfg)) - 1);
      else if (r < 5)
        it.pixel_color = 32'h0;
      it.pixel_index = pos[19:0];
    end else if (r < 94 && roomy) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_IDLE;
    end
    return it;
  endfunction

  task automatic send_item(input fbrf_in_t item);
    longint unsigned cleared;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.action == ACT_FILL) last_fill = item;
    if (item.action == ACT_CLEAR) begin
      cleared = 64'(h_act) * v_act * pb_cfg;
      if (cleared > DEF_FB_BYTES) cleared = DEF_FB_BYTES;
      if (cleared > known_len) known_len = cleared;
    end
    sent++;
    quiet = (sent % 500) >= 380;
  endtask

  // wait until every result is out and the block has settled
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_phase(input int unsigned h, input int unsigned v, input int unsigned pb);
    drain();
    write_reg(CFG_H_RES, 11'(h));
    write_reg(CFG_V_RES, 11'(v));
    write_reg(CFG_PIX_BYTES, {8'($urandom), 3'(pb)});
    h_act = (h > DEF_MAX_H_RES) ? DEF_MAX_H_RES : h;
    v_act = (v > DEF_MAX_V_RES) ? DEF_MAX_V_RES : v;
    pb_cfg = pb;
    // a clear makes the active area readable; skipped where it would take too long
    if (64'(h_act) * v_act * pb <= 65536)
      send_item(cmd(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    $urandom, 20'($urandom)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      set_phase(ph_h[p], ph_v[p], ph_pb[p]);
      if (p == 0) begin
        // 16 x 8 at 4 bytes per pixel
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'h0, 20'd0));
        send_item(cmd(ACT_FILL, 2, 1, 3, 2, 32'hA1B2_C3D4, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'hA1B2_C3D4, 20'd18));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'h0, 20'd21));
        // zero width, then zero height
        send_item(cmd(ACT_FILL, 0, 0, 0, 5, 32'hFFFF_FFFF, 20'd0));
        send_item(cmd(ACT_FILL, 0, 0, 5, 0, 32'hFFFF_FFFF, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'h0, 20'd0));
        // columns wrap past 65535 back to zero
        send_item(cmd(ACT_FILL, 16'hFFFE, 0, 4, 1, 32'h1122_3344, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'h1122_3344, 20'd1));
        // lines wrap the same way
        send_item(cmd(ACT_FILL, 0, 16'hFFFF, 1, 3, 32'h55, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'h55, 20'd16));
        // hangs over the right and bottom edges
        send_item(cmd(ACT_FILL, 15, 7, 4, 4, 32'hFFFF_FFFF, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'hFFFF_FFFF, 20'd127));
        // origin exactly on the bound, column then line
        send_item(cmd(ACT_FILL, 16, 0, 1, 1, 32'h0BAD_F00D, 20'd0));
        send_item(cmd(ACT_FILL, 0, 8, 1, 1, 32'h0BAD_F00D, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'h55, 20'd16));
        send_item(cmd(ACT_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                      20'hFFFFF));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'hFFFF_FFFF, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'hFFFF_FFFF, 20'd127));
        send_item(cmd(ACT_IDLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                      20'hFFFFF));
        send_item(cmd(ACT_CLEAR, 0, 0, 0, 0, 32'h0, 20'd0));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'hFFFF_FFFF, 20'd5));
        send_item(cmd(ACT_CHECK, 0, 0, 0, 0, 32'h0, 20'd127));
      end
      repeat (ph_n[p]) send_item(random_item());
    end
    drain();
    if (mismatches == 0) $display("framebuffer_rect_fill_tb: done, clean");
    else $display("framebuffer_rect_fill_tb: done, errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("framebuffer_rect_fill_tb: done, errors");
    $finish;
  end

endmodule

FILE: framebuffer_rect_fill.f
hdl/fbrf_pkg.sv
hdl/fbrf_seq.sv
hdl/framebuffer_rect_fill.sv
verif/fbrf_checker.sv
verif/framebuffer_rect_fill_tb.sv
